>>> rtl/escape_framer_with_crc_core_macros.svh
// Assertion macros for the escape framer checker.
// Included by efc_checker.sv; needs no other file.
`ifndef ESCAPE_FRAMER_WITH_CRC_CORE_MACROS_SVH
`define ESCAPE_FRAMER_WITH_CRC_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define EFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define EFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/efc_pkg.sv
// Shared types, constants and helper functions for the escape framer.
// No dependencies; used by efc_fifo, efc_front, efc_back and the top level.
package efc_pkg;

   localparam int CRC_WIDTH = 16;
   localparam int POLY_W = 16;
   localparam logic [POLY_W-1:0] CRC_POLY_RESET = 16'h1021;

   localparam logic [7:0] PAT_START = 8'h01;
   localparam logic [7:0] PAT_END = 8'h04;
   localparam logic [7:0] PAT_ESC = 8'h1B;
   localparam logic [7:0] SUB_START = 8'h41;
   localparam logic [7:0] SUB_END = 8'h42;
   localparam logic [7:0] SUB_ESC = 8'h43;

   localparam int WIN_W = 7;
   localparam int FILL_W = 3;
   localparam int MAX_LEN = (CRC_WIDTH > 16) ? CRC_WIDTH : 16;
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int CNT_W = $clog2(MAX_LEN);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_BIT,
      ACT_ESC_START,
      ACT_ESC_END,
      ACT_ESC_ESC
   } act_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_ACT,
      PH_FLUSH,
      PH_END,
      PH_CRC,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic start;
      act_type act;
      logic bit_val;
      logic last;
      logic [FILL_W-1:0] fill;
      logic [WIN_W-1:0] win;
      logic [CRC_WIDTH-1:0] crc;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [7:0] sub_code(input act_type act);
      logic [7:0] s;
      case (act)
         ACT_ESC_START: s = SUB_START;
         ACT_ESC_END: s = SUB_END;
         default: s = SUB_ESC;
      endcase
      return s;
   endfunction

   function automatic logic [LEN_W-1:0] phase_len(input cmd_type c, input phase_type ph);
      logic [LEN_W-1:0] n;
      case (ph)
         PH_START: n = c.start ? LEN_W'(8) : '0;
         PH_ACT: begin
            case (c.act)
               ACT_NONE: n = '0;
               ACT_BIT: n = LEN_W'(1);
               default: n = LEN_W'(16);
            endcase
         end
         PH_FLUSH: n = c.last ? LEN_W'(c.fill) : '0;
         PH_END: n = c.last ? LEN_W'(8) : '0;
         PH_CRC: n = c.last ? LEN_W'(CRC_WIDTH) : '0;
         default: n = '0;
      endcase
      return n;
   endfunction

   // first phase at or after from_ph that has bits to send
   function automatic phase_type first_phase(input cmd_type c, input phase_type from_ph);
      phase_type r;
      phase_type p;
      r = PH_DONE;
      for (int i = int'(PH_CRC); i >= int'(PH_START); i--) begin
         p = phase_type'(i);
         if (i >= int'(from_ph) && phase_len(c, p) != '0) begin
            r = p;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/efc_fifo.sv
// Short command queue between the classifier and the bit sequencer.
// Depends on efc_pkg for the command type and depth.
module efc_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  efc_pkg::cmd_type         wr_data,
   input  logic                     rd_en,
   output efc_pkg::cmd_type         rd_data,
   output efc_pkg::fifo_status_type status
);
   import efc_pkg::*;

   cmd_type mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign do_wr = wr_en && !status.full;
   assign do_rd = rd_en && !status.empty;

   always_comb begin
      wr_ptr_in = do_wr ? FIFO_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? FIFO_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign status.full = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> rtl/efc_front.sv
// Input side: keeps window, fill, CRC and frame state, classifies each request.
// Depends on efc_pkg; pushes one command per request that produces output.
module efc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   input  logic                              req_tlast,
   input  logic                              csr_we,
   input  logic [efc_pkg::POLY_W-1:0]        csr_wdata,
   input  efc_pkg::fifo_status_type          q_status,
   output logic                              q_push,
   output efc_pkg::cmd_type                  q_cmd
);
   import efc_pkg::*;

   logic [POLY_W-1:0] poly_ff;
   logic [WIN_W-1:0] win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CRC_WIDTH-1:0] crc_ff, crc_in;
   logic open_ff, open_in;

   logic accept;
   logic in_bit;
   logic [7:0] new_win;
   logic [FILL_W:0] fill_inc;
   logic win_full;
   logic fb;
   logic [31:0] poly_wide;
   logic [CRC_WIDTH-1:0] poly_eff;
   logic [CRC_WIDTH-1:0] crc_new;
   act_type act;
   logic [WIN_W-1:0] win_after;
   logic [FILL_W-1:0] fill_after;

   assign req_tready = !q_status.full;
   assign accept = req_tvalid && req_tready;
   assign in_bit = req_tdata[0];

   always_comb begin
      poly_wide = {{(32-POLY_W){1'b0}}, poly_ff};
      poly_eff = poly_wide[CRC_WIDTH-1:0];
      fb = crc_ff[CRC_WIDTH-1] ^ in_bit;
      crc_new = (crc_ff << 1) ^ (fb ? poly_eff : '0);

      new_win = {win_ff, in_bit};
      fill_inc = {1'b0, fill_ff} + 1'b1;
      win_full = fill_inc[FILL_W];

      act = ACT_NONE;
      win_after = new_win[WIN_W-1:0];
      fill_after = fill_inc[FILL_W-1:0];
      if (win_full) begin
         if (new_win == PAT_START) begin
            act = ACT_ESC_START;
         end else if (new_win == PAT_END) begin
            act = ACT_ESC_END;
         end else if (new_win == PAT_ESC) begin
            act = ACT_ESC_ESC;
         end else begin
            act = ACT_BIT;
         end
         // escape consumes the whole window; a plain bit keeps the newest seven
         if (act == ACT_BIT) begin
            fill_after = FILL_W'(7);
         end else begin
            win_after = '0;
            fill_after = '0;
         end
      end

      q_cmd.start = !open_ff;
      q_cmd.act = act;
      q_cmd.bit_val = new_win[7];
      q_cmd.last = req_tlast;
      q_cmd.fill = fill_after;
      q_cmd.win = win_after;
      q_cmd.crc = crc_new;
      q_push = accept && (!open_ff || win_full || req_tlast);
   end

   always_comb begin
      win_in = win_ff;
      fill_in = fill_ff;
      crc_in = crc_ff;
      open_in = open_ff;
      if (accept) begin
         if (req_tlast) begin
            win_in = '0;
            fill_in = '0;
            crc_in = '0;
            open_in = 1'b0;
         end else begin
            win_in = win_after;
            fill_in = fill_after;
            crc_in = crc_new;
            open_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= CRC_POLY_RESET;
         win_ff <= '0;
         fill_ff <= '0;
         crc_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            poly_ff <= csr_wdata;
         end
         win_ff <= win_in;
         fill_ff <= fill_in;
         crc_ff <= crc_in;
         open_ff <= open_in;
      end
   end

endmodule

>>> rtl/efc_back.sv
// Output side: walks the phases of the command at the queue head, one bit per cycle
// while rsp is not stalled. Depends on efc_pkg; drives the registered result stage.
module efc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  efc_pkg::cmd_type         q_cmd,
   input  efc_pkg::fifo_status_type q_status,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);
   import efc_pkg::*;

   phase_type ph_ff, ph_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic fresh_ff, fresh_in;
   logic valid_ff, valid_in;
   logic bit_ff, bit_in;
   logic last_ff, last_in;
   logic end_ff, end_in;

   phase_type cur_ph;
   phase_type nxt_ph;
   logic [LEN_W-1:0] cur_len;
   logic at_end;
   logic done;
   logic fire;
   logic cur_bit;
   logic [15:0] esc_pair;
   logic [CRC_WIDTH-1:0] crc_sh;
   logic [2:0] flush_idx;

   // next-state logic
   always_comb begin
      cur_ph = fresh_ff ? first_phase(q_cmd, PH_START) : ph_ff;
      cur_len = phase_len(q_cmd, cur_ph);
      at_end = (LEN_W'(cnt_ff) == LEN_W'(cur_len - 1'b1));
      nxt_ph = first_phase(q_cmd, phase_type'(cur_ph + 1'b1));
      done = at_end && (nxt_ph == PH_DONE);
      fire = !q_status.empty && (!valid_ff || rsp_tready);

      ph_in = ph_ff;
      cnt_in = cnt_ff;
      fresh_in = fresh_ff;
      if (fire) begin
         if (at_end) begin
            cnt_in = '0;
            fresh_in = done;
            ph_in = done ? PH_START : nxt_ph;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            fresh_in = 1'b0;
            ph_in = cur_ph;
         end
      end
   end

   // output logic
   always_comb begin
      esc_pair = {PAT_ESC, sub_code(q_cmd.act)};
      crc_sh = q_cmd.crc << cnt_ff;
      flush_idx = 3'(q_cmd.fill - 1'b1 - cnt_ff[2:0]);
      case (cur_ph)
         PH_START: cur_bit = PAT_START[3'(3'd7 - cnt_ff[2:0])];
         PH_ACT: cur_bit = (q_cmd.act == ACT_BIT) ? q_cmd.bit_val
                                                 : esc_pair[4'(4'd15 - cnt_ff[3:0])];
         PH_FLUSH: cur_bit = (flush_idx == 3'd7) ? 1'b0 : q_cmd.win[flush_idx];
         PH_END: cur_bit = PAT_END[3'(3'd7 - cnt_ff[2:0])];
         PH_CRC: cur_bit = crc_sh[CRC_WIDTH-1];
         default: cur_bit = 1'b0;
      endcase

      q_pop = fire && done;
      valid_in = valid_ff;
      bit_in = bit_ff;
      last_in = last_ff;
      end_in = end_ff;
      if (fire) begin
         valid_in = 1'b1;
         bit_in = cur_bit;
         last_in = done;
         end_in = done && (cur_ph == PH_CRC);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_START;
         cnt_ff <= '0;
         fresh_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         cnt_ff <= cnt_in;
         fresh_ff <= fresh_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      last_ff <= last_in;
      end_ff <= end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {7'b0, bit_ff};
   assign rsp_tlast = last_ff;
   assign rsp_tuser = end_ff;

endmodule

>>> rtl/escape_framer_with_crc_core.sv
// Channel | Dir | Handshake         | Content
// req     | in  | tvalid/tready     | tdata[0] payload bit, tlast last payload bit of frame
// rsp     | out | tvalid/tready     | tdata[0] line bit, tlast last bit of a request, tuser frame end
// csr     | in  | csr_we            | csr_wdata CRC polynomial, top bit implied
// One request is taken per cycle while the four-entry command queue has room.
// Results leave at one bit per cycle while rsp is not stalled, via a registered output stage;
// a request expands to 0..40 bits, so the sustained request rate is set by the output bit count.
// Reset is synchronous; with no clearing pass, the block is ready once reset is released.
// A stalled rsp side fills the queue, then req_tready drops.
// Top level of the escape framer; instantiates efc_front, efc_fifo and efc_back.
module escape_framer_with_crc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] in_bit, [7:1] zero
   input  logic                       req_tlast,   // payload_last
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [0] out_bit, [7:1] zero
   output logic                       rsp_tlast,   // run_last
   output logic                       rsp_tuser,   // [0] frame_end
   input  logic                       csr_we,
   input  logic [efc_pkg::POLY_W-1:0] csr_wdata
);
   import efc_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   fifo_status_type q_status;
   logic q_push;
   logic q_pop;

   efc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   efc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (push_cmd),
      .rd_en   (q_pop),
      .rd_data (head_cmd),
      .status  (q_status)
   );

   efc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_cmd      (head_cmd),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/efc_checker.sv
// Port-level checks for escape_framer_with_crc_core, bound to the top level.
// Depends on escape_framer_with_crc_core_macros.svh.
`include "escape_framer_with_crc_core_macros.svh"

module efc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   `EFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "rsp changed while stalled")
   `EFC_ASSERT_NOW(a_end_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "frame end not on last bit of request")
   `EFC_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[7:1] == 7'd0, "rsp_tdata padding not zero")
   `EFC_ASSERT_NEXT(a_start_after_end, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser, !rsp_tvalid || !rsp_tdata[0], "new frame does not open with start pattern")

endmodule

bind escape_framer_with_crc_core efc_checker u_efc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/escape_framer_with_crc_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for escape_framer_with_crc_core: escaping, flush, end pattern and CRC.
// Needs efc_pkg and the framer RTL; an in-bench bit-level encoder predicts every line bit.
module escape_framer_with_crc_core_test;
   import efc_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 12;
   localparam int ITEMS_PER_POLY = 40;
   localparam int N_DIR = 26;

   typedef struct packed {
      logic line_bit;
      logic req_end;
      logic frame_done;
   } line_bit_type;

   // in_bit, payload_last, line bits the request must produce
   typedef struct packed {
      logic       in_bit;
      logic       last;
      logic [7:0] n_bits;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      // single-bit frames: start, the bit, end, CRC
      '{1'b1, 1'b1, 8'd33}, '{1'b0, 1'b1, 8'd33},
      // start pattern in the payload
      '{1'b0, 1'b0, 8'd8}, '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0},
      '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b1, 1'b0, 8'd16},
      // end pattern
      '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0},
      '{1'b0, 1'b0, 8'd0}, '{1'b1, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd16},
      // escape pattern closing the frame: escape, end, CRC with nothing to flush
      '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b1, 1'b0, 8'd0},
      '{1'b1, 1'b0, 8'd0}, '{1'b0, 1'b0, 8'd0}, '{1'b1, 1'b0, 8'd0}, '{1'b1, 1'b1, 8'd40}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_we;
   logic [POLY_W-1:0]    csr_wdata;

   // encoder state
   logic [7:0]           win;
   logic [3:0]           fill;
   logic [CRC_WIDTH-1:0] crc_acc;
   logic                 framing;
   logic [POLY_W-1:0]    poly_now;

   line_bit_type         line_bits_due[$];
   int                   errors = 0;
   int                   req_count = 0;
   int                   frames_done = 0;
   int                   escapes_seen = 0;
   int                   bits_checked = 0;
   int                   burst_left = 0;
   int                   idle_cycles = 0;
   logic [7:0]           stall_tick = '0;
   logic [1:0]           stall_mode = '0;

   escape_framer_with_crc_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void push_line(input logic v, input logic fe);
      line_bit_type e;
      e.line_bit = v;
      e.req_end = 1'b0;
      e.frame_done = fe;
      line_bits_due.push_back(e);
   endfunction

   function automatic void push_byte(input logic [7:0] p);
      for (int k = 7; k >= 0; k--) push_line(p[k], 1'b0);
   endfunction

   function automatic void clear_encoder();
      win = '0;
      fill = '0;
      crc_acc = '0;
      framing = 1'b0;
   endfunction

   // Append the line bits one payload bit produces; return their count.
   function automatic int encode_bit(input logic b, input logic l);
      int           n0;
      logic [7:0]   sub;
      logic         fb;
      line_bit_type tail;
      n0 = line_bits_due.size();
      if (!framing) begin
         push_byte(PAT_START);
         framing = 1'b1;
      end
      fb = crc_acc[CRC_WIDTH-1] ^ b;
      crc_acc = {crc_acc[CRC_WIDTH-2:0], 1'b0} ^ (fb ? poly_now[CRC_WIDTH-1:0] : '0);
      win = {win[6:0], b};
      if (fill < 4'd8) fill = fill + 4'd1;
      if (fill == 4'd8) begin
         sub = 8'h00;
         case (win)
            PAT_START: sub = SUB_START;
            PAT_END:   sub = SUB_END;
            PAT_ESC:   sub = SUB_ESC;
            default:   sub = 8'h00;
         endcase
         if (sub != 8'h00) begin
            push_byte(PAT_ESC);
            push_byte(sub);
            win = '0;
            fill = '0;
            escapes_seen++;
         end else begin
            push_line(win[7], 1'b0);
            win[7] = 1'b0;
            fill = 4'd7;
         end
      end
      if (l) begin
         for (int k = int'(fill) - 1; k >= 0; k--) push_line(win[k], 1'b0);
         push_byte(PAT_END);
         for (int k = CRC_WIDTH - 1; k >= 0; k--) push_line(crc_acc[k], k == 0);
         clear_encoder();
         frames_done++;
      end
      if (line_bits_due.size() > n0) begin
         tail = line_bits_due.pop_back();
         tail.req_end = 1'b1;
         line_bits_due.push_back(tail);
      end
      return line_bits_due.size() - n0;
   endfunction

   // Send in bursts with random gaps; predict at the accepting edge.
   task automatic send_request(input logic b, input logic l, output int produced);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, b};
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      produced = encode_bit(b, l);
      req_count++;
      burst_left--;
   endtask

   // Mostly random bits, with the three reserved patterns dropped in often.
   task automatic send_random_frame(input int n_bits);
      int         sent;
      int         dummy;
      logic [7:0] pat;
      sent = 0;
      while (sent < n_bits) begin
         if ($urandom_range(0, 3) == 0 && n_bits - sent >= 8) begin
            case ($urandom_range(0, 2))
               0:       pat = PAT_START;
               1:       pat = PAT_END;
               default: pat = PAT_ESC;
            endcase
            for (int k = 7; k >= 0; k--) begin
               send_request(pat[k], sent == n_bits - 1, dummy);
               sent++;
            end
         end else begin
            send_request(1'($urandom_range(0, 1)), sent == n_bits - 1, dummy);
            sent++;
         end
      end
   endtask

   // Hold requests until every line bit is out, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (line_bits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_poly(input logic [POLY_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      poly_now = value;
   endtask

   // receiver: pick a new stall pattern each time stall_tick[5:0] returns to zero
   always @(posedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_tready <= (stall_tick % 5 != 0);
         default: rsp_tready <= stall_tick[3];
      endcase
   end

   always @(posedge clock) begin : line_check
      line_bit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bits_checked++;
         if (line_bits_due.size() == 0) begin
            $error("line bit %0b arrived with nothing pending", rsp_tdata[0]);
            errors++;
         end else begin
            want = line_bits_due.pop_front();
            if (rsp_tdata[0] !== want.line_bit) begin
               $error("out_bit: expected %0b, got %0b", want.line_bit, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tlast !== want.req_end) begin
               $error("run_last: expected %0b, got %0b", want.req_end, rsp_tlast);
               errors++;
            end
            if (rsp_tuser !== want.frame_done) begin
               $error("frame_end: expected %0b, got %0b", want.frame_done, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      int               produced;
      int               first_req;
      logic [POLY_W-1:0] polys [4];
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      clear_encoder();
      poly_now = CRC_POLY_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIR; r++) begin
         send_request(DIR_ROWS[r].in_bit, DIR_ROWS[r].last, produced);
         if (produced != int'(DIR_ROWS[r].n_bits)) begin
            $error("request %0d: expected %0d line bits, encoder gave %0d",
                   r, DIR_ROWS[r].n_bits, produced);
            errors++;
         end
      end

      polys[0] = CRC_POLY_RESET;
      polys[1] = '1;
      polys[2] = '0;
      polys[3] = POLY_W'($urandom_range(0, 65535));
      for (int p = 0; p < 4; p++) begin
         if (p > 0) begin
            drain();
            write_poly(polys[p]);
         end
         first_req = req_count;
         while (req_count - first_req < ITEMS_PER_POLY)
            send_random_frame(($urandom_range(0, 7) == 0) ? $urandom_range(30, 48)
                                                          : $urandom_range(1, 16));
      end
      drain();

      $display("Covered %0d requests in %0d frames under 4 polynomials (reset, all ones,",
               req_count, frames_done);
      $display("zero, random): %0d escapes, %0d line bits checked", escapes_seen,
               bits_checked);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/efc_pkg.sv
rtl/efc_fifo.sv
rtl/efc_front.sv
rtl/efc_back.sv
rtl/escape_framer_with_crc_core.sv
rtl/efc_checker.sv
tb/escape_framer_with_crc_core_test.sv
